// File: rtl/nrs_pkg.sv
`timescale 1ns / 1ps

package nrs_pkg;

    localparam int DEF_MAX_DIMS   = 64;
    localparam int DEF_MAX_ROWS   = 65536;
    localparam int DEF_VALUE_BITS = 16;

    // dims_in_use register width and distance width are fixed by the interface
    localparam int CFG_W  = 7;
    localparam int DIST_W = 38;

    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_TARGET = 1'b1;

    // control bits that ride along with a word through the pipe
    typedef struct packed {
        logic valid;
        logic target;
        logic row_end;
        logic last;
    } nrs_ctl_t;

endpackage

// File: rtl/nearest_row_search.sv
`timescale 1ns / 1ps
// The last word's result passes the p1, p2 and output registers before it appears on m_tvalid.
// Throughput: one word per cycle while s_tready is high, which also enables the query RAM read.
// s_tready drops only while a result waits on m_tvalid and a second result reaches the
// accumulate stage.
// Reset: rst_n clears all control and search state and sets dims_in_use to 1; the query
// store RAM is not cleared.

module nearest_row_search
    import nrs_pkg::*;
#(
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    localparam int ROW_W      = $clog2(MAX_ROWS + 1),
    localparam int IN_DATA_W  = ((VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((ROW_W + DIST_W + 7) / 8) * 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_data,    // dims_in_use
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,     // element_value
    input  logic                  s_tuser,     // operation
    input  logic                  s_tlast,     // last_element
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,     // best_row, best_distance_sq
    output logic                  m_tuser      // rows_overflowed
);

    localparam int COL_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    logic                  advance;
    logic                  ram_we;
    logic [COL_W-1:0]      ram_waddr;
    logic [COL_W-1:0]      ram_raddr;
    logic [VALUE_BITS-1:0] query_value;
    nrs_ctl_t              p1_ctl;
    logic [VALUE_BITS-1:0] p1_value;
    logic [ROW_W-1:0]      out_row;
    logic [DIST_W-1:0]     out_dist;

    nrs_front #(
        .MAX_DIMS   (MAX_DIMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_value  (s_tdata[VALUE_BITS-1:0]),
        .in_last   (s_tlast),
        .advance   (advance),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_raddr (ram_raddr),
        .p1_ctl    (p1_ctl),
        .p1_value  (p1_value)
    );

    nrs_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_DIMS)
    ) u_query_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata[VALUE_BITS-1:0]),
        .re    (advance),
        .raddr (ram_raddr),
        .rdata (query_value)
    );

    nrs_accum #(
        .MAX_ROWS   (MAX_ROWS),
        .VALUE_BITS (VALUE_BITS)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .p1_ctl      (p1_ctl),
        .p1_value    (p1_value),
        .query_value (query_value),
        .out_ready   (m_tready),
        .advance     (advance),
        .out_valid   (m_tvalid),
        .out_row     (out_row),
        .out_dist    (out_dist),
        .out_ovf     (m_tuser)
    );

    assign s_tready = advance;
    assign m_tdata  = OUT_DATA_W'({out_dist, out_row});

endmodule

// File: rtl/nrs_ram.sv
`timescale 1ns / 1ps

module nrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/nrs_front.sv
`timescale 1ns / 1ps

module nrs_front
    import nrs_pkg::*;
#(
    parameter int MAX_DIMS   = DEF_MAX_DIMS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    localparam int COL_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
    localparam int FILL_W = $clog2(MAX_DIMS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  in_valid,
    input  logic                  in_op,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic                  in_last,
    input  logic                  advance,
    output logic                  ram_we,
    output logic [COL_W-1:0]      ram_waddr,
    output logic [COL_W-1:0]      ram_raddr,
    output nrs_ctl_t              p1_ctl,
    output logic [VALUE_BITS-1:0] p1_value
);

    localparam int CMP_W = (CFG_W > FILL_W) ? CFG_W : FILL_W;

    logic [CFG_W-1:0]      dims_reg;
    logic [COL_W-1:0]      col_reg;
    logic [COL_W-1:0]      col_next;
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    nrs_ctl_t              ctl_reg;
    nrs_ctl_t              ctl_next;
    logic [VALUE_BITS-1:0] value_reg;

    logic [FILL_W-1:0] eff_dims;
    logic [FILL_W-1:0] fill_base;
    logic [FILL_W-1:0] col_inc;
    logic              row_end;
    logic              accept;

    // zero acts as one, anything above the store depth is clamped
    always_comb
    begin
        if (dims_reg == '0)
        begin
            eff_dims = FILL_W'(1);
        end
        else if (CMP_W'(dims_reg) > CMP_W'(MAX_DIMS))
        begin
            eff_dims = FILL_W'(MAX_DIMS);
        end
        else
        begin
            eff_dims = FILL_W'(dims_reg);
        end
    end

    assign accept    = in_valid && advance;
    assign fill_base = (fill_reg >= eff_dims) ? '0 : fill_reg;
    assign col_inc   = FILL_W'(col_reg) + FILL_W'(1);
    assign row_end   = (col_inc >= eff_dims);

    assign ram_we    = accept && (in_op == OP_QUERY);
    assign ram_waddr = fill_base[COL_W-1:0];
    assign ram_raddr = col_reg;

    always_comb
    begin
        col_next  = col_reg;
        fill_next = fill_reg;
        ctl_next  = ctl_reg;
        if (advance)
        begin
            ctl_next.valid   = accept;
            ctl_next.target  = (in_op == OP_TARGET);
            ctl_next.row_end = row_end;
            ctl_next.last    = (in_op == OP_TARGET) && in_last;
        end
        if (accept)
        begin
            if (in_op == OP_QUERY)
            begin
                col_next  = '0;
                fill_next = fill_base + FILL_W'(1);
            end
            else
            begin
                col_next = (row_end || in_last) ? '0 : col_inc[COL_W-1:0];
                if (in_last)
                begin
                    fill_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= CFG_W'(1);
            col_reg  <= '0;
            fill_reg <= '0;
            ctl_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                dims_reg <= cfg_data;
            end
            col_reg  <= col_next;
            fill_reg <= fill_next;
            ctl_reg  <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg <= in_value;
        end
    end

    assign p1_ctl   = ctl_reg;
    assign p1_value = value_reg;

endmodule

// File: rtl/nrs_accum.sv
`timescale 1ns / 1ps

module nrs_accum
    import nrs_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    localparam int ROW_W = $clog2(MAX_ROWS + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  nrs_ctl_t              p1_ctl,
    input  logic [VALUE_BITS-1:0] p1_value,
    input  logic [VALUE_BITS-1:0] query_value,
    input  logic                  out_ready,
    output logic                  advance,
    output logic                  out_valid,
    output logic [ROW_W-1:0]      out_row,
    output logic [DIST_W-1:0]     out_dist,
    output logic                  out_ovf
);

    localparam int SQ_W  = 2 * VALUE_BITS;
    localparam int SUM_W = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // square stage
    logic signed [VALUE_BITS:0] diff;
    logic [VALUE_BITS-1:0]      mag;
    logic [SQ_W-1:0]            sq;

    nrs_ctl_t        p2_ctl_reg;
    logic [SQ_W-1:0] p2_sq_reg;

    // search state
    logic [DIST_W-1:0] acc_reg;
    logic [DIST_W-1:0] acc_next;
    logic [ROW_W-1:0]  rows_reg;
    logic [ROW_W-1:0]  rows_next;
    logic [DIST_W-1:0] best_dist_reg;
    logic [DIST_W-1:0] best_dist_next;
    logic [ROW_W-1:0]  best_idx_reg;
    logic [ROW_W-1:0]  best_idx_next;
    logic              ovf_reg;
    logic              ovf_next;

    logic [SUM_W-1:0]  sum;
    logic [DIST_W-1:0] acc_add;
    logic              res_load;
    logic [ROW_W-1:0]  res_row;
    logic [DIST_W-1:0] res_dist;
    logic              res_ovf;

    logic              out_valid_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [DIST_W-1:0] out_dist_reg;
    logic              out_ovf_reg;

    assign diff = $signed({p1_value[VALUE_BITS-1], p1_value})
                - $signed({query_value[VALUE_BITS-1], query_value});
    assign mag  = diff[VALUE_BITS] ? VALUE_BITS'(-diff) : VALUE_BITS'(diff);
    assign sq   = mag * mag;

    // stall only when a second result would land on a full output word
    assign advance = !(p2_ctl_reg.valid && p2_ctl_reg.last && out_valid_reg && !out_ready);

    assign sum     = SUM_W'(acc_reg) + SUM_W'(p2_sq_reg);
    assign acc_add = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];

    always_comb
    begin
        acc_next       = acc_reg;
        rows_next      = rows_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        ovf_next       = ovf_reg;
        res_load       = 1'b0;
        res_row        = best_idx_reg;
        res_dist       = best_dist_reg;
        res_ovf        = ovf_reg;
        if (p2_ctl_reg.valid && advance)
        begin
            if (!p2_ctl_reg.target)
            begin
                // query load restarts the search
                acc_next       = '0;
                rows_next      = '0;
                best_dist_next = '0;
                best_idx_next  = '0;
                ovf_next       = 1'b0;
            end
            else
            begin
                if (p2_ctl_reg.row_end)
                begin
                    if (rows_reg < ROW_W'(MAX_ROWS))
                    begin
                        rows_next = rows_reg + ROW_W'(1);
                        // strict compare: ties keep the earlier row
                        if ((best_idx_reg == '0) || (acc_add < best_dist_reg))
                        begin
                            best_dist_next = acc_add;
                            best_idx_next  = rows_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    acc_next = '0;
                end
                else
                begin
                    acc_next = acc_add;
                end
                if (p2_ctl_reg.last)
                begin
                    res_load       = 1'b1;
                    // values after this word's row update, before the clear
                    res_row        = best_idx_next;
                    res_dist       = best_dist_next;
                    res_ovf        = ovf_next;
                    acc_next       = '0;
                    rows_next      = '0;
                    best_dist_next = '0;
                    best_idx_next  = '0;
                    ovf_next       = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_ctl_reg    <= '0;
            acc_reg       <= '0;
            rows_reg      <= '0;
            best_dist_reg <= '0;
            best_idx_reg  <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                p2_ctl_reg <= p1_ctl;
            end
            acc_reg       <= acc_next;
            rows_reg      <= rows_next;
            best_dist_reg <= best_dist_next;
            best_idx_reg  <= best_idx_next;
            ovf_reg       <= ovf_next;
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            p2_sq_reg <= sq;
        end
        if (res_load)
        begin
            // index zero carries distance zero, as the state is cleared together
            out_row_reg  <= res_row;
            out_dist_reg <= res_dist;
            out_ovf_reg  <= res_ovf;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_dist  = out_dist_reg;
    assign out_ovf   = out_ovf_reg;

endmodule

// File: rtl/nrs_checker.sv
`timescale 1ns / 1ps

module nrs_checker
    import nrs_pkg::*;
#(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    localparam int ROW_W      = $clog2(MAX_ROWS + 1),
    localparam int IN_DATA_W  = ((VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((ROW_W + DIST_W + 7) / 8) * 8
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser
);

    // a held result word stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // input side only backs up behind an unread result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with no result waiting");

    // an offered input word is held until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input word changed while stalled");

    // no row found means distance zero
    a_empty_dist: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[ROW_W-1:0] == '0) |-> (m_tdata[ROW_W+DIST_W-1:ROW_W] == '0))
        else $error("distance nonzero with no best row");

    // best row never exceeds the row limit
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[ROW_W-1:0] <= ROW_W'(MAX_ROWS)))
        else $error("best row beyond row limit");

endmodule

bind nearest_row_search nrs_checker #(
    .MAX_ROWS   (MAX_ROWS),
    .VALUE_BITS (VALUE_BITS)
) u_nrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
